// File: rtl/sha256_pkg.sv
package sha256_pkg;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PAD   = 7'b0000010,
        ST_LEN   = 7'b0000100,
        ST_ROUND = 7'b0001000,
        ST_FOLD  = 7'b0010000,
        ST_OUT   = 7'b0100000,
        ST_LOAD  = 7'b1000000
    } state_t;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

endpackage

// File: rtl/sha256_hash_engine_top.sv
// SHA-256 engine over a byte stream. Each input item carries an optional
// byte (tuser[0] = byte present) and tlast ends the message. A byte that does
// not complete a 64-byte block is taken without a stall; a byte that completes
// a block holds tready low through the load, the 64 rounds and the fold,
// since one round unit works the whole compression one round per
// cycle with a 16-word rolling schedule window. Message bytes are written
// straight into that window. At end of message padding is written one byte
// per cycle from the pad position to the end of the block and the block is
// compressed; when the pad byte lands at offset 56 or later, a second block
// of zeros and the length is written and compressed as well. If the ending
// item also completed a block, that block is compressed first. Eight digest
// words then leave on the master side, word 0 first with tlast on word 7. The
// block takes no item until all are taken.
module sha256_hash_engine_top
    import sha256_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tuser,   // byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // digest_word
    output logic [2:0]  m_tuser,   // word_index
    output logic        m_tlast    // last_word
);

    state_t      state_reg, state_next;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [60:0] count_reg;
    logic [5:0]  rnd_reg;
    logic [5:0]  pad_reg;
    logic [2:0]  oidx_reg;
    logic        final_reg;   // compression in flight is the last of the message
    logic        extra_reg;   // after this compression, write another pad block
    logic        pend_reg;    // end of message waits for the block in flight
    logic [63:0] bits;

    logic        take;
    logic [5:0]  fill;
    logic [31:0] wt, s0, s1, e1, ch, e0, mj, p, q, wnew;

    assign s_tready = (state_reg == ST_IDLE);
    assign take     = s_tvalid && s_tready;
    assign fill     = count_reg[5:0];
    assign bits     = {count_reg, 3'b000};

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = h_reg[oidx_reg];
    assign m_tuser  = oidx_reg;
    assign m_tlast  = (oidx_reg == 3'd7);

    // Round unit: one SHA-256 round and one schedule word per cycle.
    always_comb
    begin
        wt   = w_reg[0];
        s0   = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1   = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = s1 + w_reg[9] + s0 + w_reg[0];
        e1   = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        e0   = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        mj   = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        p    = v_reg[7] + e1 + ch + wt + RK[rnd_reg];
        q    = e0 + mj;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    if (s_tuser && fill == 6'd63)
                        state_next = ST_LOAD;
                    else if (s_tlast)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:
            begin
                // A pad byte in the last position leaves nothing else to write.
                if (pad_reg == 6'd63)
                    state_next = ST_LOAD;
                else
                    state_next = ST_LEN;
            end
            ST_LEN:
            begin
                if (pad_reg == 6'd63)
                    state_next = ST_LOAD;
            end
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (rnd_reg == 6'd63)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                if (extra_reg)
                    state_next = ST_LEN;
                else if (final_reg)
                    state_next = ST_OUT;
                else if (pend_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (m_tready && oidx_reg == 3'd7)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Block byte writes: one per cycle, big-endian within each schedule word.
    logic       bw_en;
    logic [5:0] bw_addr;
    logic [7:0] bw_data;

    always_comb
    begin
        bw_en   = 1'b0;
        bw_addr = fill;
        bw_data = s_tdata;
        case (state_reg)
            ST_IDLE:
            begin
                bw_en = take && s_tuser;
            end
            ST_PAD:
            begin
                bw_en   = 1'b1;
                bw_addr = pad_reg;
                bw_data = PAD_BYTE;
            end
            ST_LEN:
            begin
                bw_en   = 1'b1;
                bw_addr = pad_reg;
                bw_data = 8'h00;
                if (!extra_reg && pad_reg >= LEN_START)
                    bw_data = bits[6'(63 - 8 * int'(pad_reg - LEN_START)) -: 8];
            end
            default:  bw_en = 1'b0;
        endcase
    end

    // The schedule window holds the block bytes until the rounds start.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= wnew;
        end
        else if (bw_en)
            w_reg[bw_addr[5:2]][{~bw_addr[1:0], 3'b000} +: 8] <= bw_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            rnd_reg   <= '0;
            pad_reg   <= '0;
            oidx_reg  <= '0;
            final_reg <= 1'b0;
            extra_reg <= 1'b0;
            pend_reg  <= 1'b0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= IV[i];
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        final_reg <= 1'b0;
                        extra_reg <= 1'b0;
                        // Remember a pending end of message for after the block.
                        pend_reg  <= s_tuser && fill == 6'd63 && s_tlast;
                        if (s_tuser)
                            count_reg <= count_reg + 61'd1;
                        if (s_tlast && !(s_tuser && fill == 6'd63))
                            pad_reg <= s_tuser ? fill + 6'd1 : fill;
                        else
                            pad_reg <= '0;
                    end
                end
                ST_PAD:
                begin
                    extra_reg <= (pad_reg >= LEN_START);
                    pad_reg   <= pad_reg + 6'd1;
                end
                ST_LEN:
                begin
                    pad_reg <= pad_reg + 6'd1;
                    if (pad_reg == 6'd63)
                        final_reg <= !extra_reg;
                end
                ST_LOAD:
                begin
                    rnd_reg <= '0;
                    for (int i = 0; i < 8; i++)
                        v_reg[i] <= h_reg[i];
                end
                ST_ROUND:
                begin
                    rnd_reg  <= rnd_reg + 6'd1;
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + p;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= p + q;
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    extra_reg <= 1'b0;
                    pend_reg  <= 1'b0;
                    pad_reg   <= '0;
                    oidx_reg  <= '0;
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= IV[i];
                            count_reg <= '0;
                            final_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tuser)))
        else $error("digest word dropped while stalled");
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input accepted while digest pending");
    a_round_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> (state_reg == ST_ROUND && rnd_reg == 6'd0))
        else $error("round counter not restarted");

endmodule
